/* rtl/core/bst_pkg.sv */
// Shared types and constants for the bencode stream tokenizer.
// Used by the parser front end, the record queue and the token emitter.
// No dependencies.
package bst_pkg;

    // Default configuration of the block.
    localparam int LENGTH_BITS_DEF = 32;
    localparam int LEVEL_BITS_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Field widths of one result item.
    localparam int KIND_W  = 4;
    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 63;
    localparam int NEST_W  = 8;
    localparam int SLOTS   = 3;

    // Largest decimal value the accumulator holds.
    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    // Bytes with a meaning outside string payload.
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // Parser mode.
    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_LEN,
        MODE_INT,
        MODE_PAY
    } mode_t;

    // Token kinds on the output.
    typedef enum logic [KIND_W-1:0] {
        TK_BYTE    = 4'd0,
        TK_EMPTY   = 4'd1,
        TK_INT     = 4'd2,
        TK_OPEN    = 4'd3,
        TK_CLOSE   = 4'd4,
        TK_NOCOLON = 4'd5,
        TK_NOE     = 4'd6,
        TK_END_OK  = 4'd7,
        TK_CORRUPT = 4'd8
    } tok_kind_t;

    // All tokens caused by one input byte. Only slot 0 can be a string byte
    // or an integer, so the payload, value and end flag belong to slot 0.
    typedef struct packed {
        logic [1:0]                    count;
        logic [SLOTS-1:0][KIND_W-1:0] kind;
        logic [SLOTS-1:0][NEST_W-1:0] level;
        logic [BYTE_W-1:0]             payload;
        logic [VALUE_W-1:0]            value;
        logic                          str_end;
    } step_rec_t;

endpackage

/* rtl/core/bst_front.sv */
// Parser front end: accepts stream bytes, keeps the parse state and builds
// one record of up to three tokens per byte. Depends on bst_pkg.
module bst_front #(
    parameter int LENGTH_BITS = bst_pkg::LENGTH_BITS_DEF,
    parameter int LEVEL_BITS  = bst_pkg::LEVEL_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_eos,
    input  logic                queue_full,
    output logic                push,
    output bst_pkg::step_rec_t  rec
);

    localparam int EXT_W = (LEVEL_BITS > bst_pkg::NEST_W) ? LEVEL_BITS : bst_pkg::NEST_W;
    localparam logic signed [LEVEL_BITS-1:0] LVL_MAX = {1'b0, {(LEVEL_BITS-1){1'b1}}};
    localparam logic signed [LEVEL_BITS-1:0] LVL_MIN = {1'b1, {(LEVEL_BITS-1){1'b0}}};

    bst_pkg::mode_t                        mode_reg, mode_next;
    logic [bst_pkg::VALUE_W-1:0]           acc_reg, acc_next;
    logic [LENGTH_BITS-1:0]                rem_reg, rem_next;
    logic signed [LEVEL_BITS-1:0]          lvl_reg, lvl_next;

    logic                                  accept;
    logic                                  is_digit;
    logic [3:0]                            digit;
    logic [bst_pkg::VALUE_W-1:0]           acc_step;
    logic [bst_pkg::VALUE_W+3:0]           acc_wide;
    logic [LENGTH_BITS-1:0]                len_sat;
    logic [bst_pkg::NEST_W-1:0]            lvl_old_field;

    // Clamp a level to the signed range of the nesting field.
    function automatic logic [bst_pkg::NEST_W-1:0] clamp_level(
        input logic signed [LEVEL_BITS-1:0] lvl
    );
        logic signed [EXT_W-1:0] ext;
        logic [bst_pkg::NEST_W-1:0] res;
        begin
            ext = EXT_W'(lvl);
            if (ext > 127)
                res = 8'sd127;
            else if (ext < -128)
                res = 8'h80;
            else
                res = ext[bst_pkg::NEST_W-1:0];
            return res;
        end
    endfunction

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // Decimal digit step: acc * 10 + d, saturated at the largest value.
    assign is_digit = (in_byte >= bst_pkg::CH_0) && (in_byte <= bst_pkg::CH_9);
    assign digit    = 4'(in_byte - bst_pkg::CH_0);
    assign acc_wide = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                      + {{bst_pkg::VALUE_W{1'b0}}, digit};
    assign acc_step = (acc_wide > {4'b0000, bst_pkg::VALUE_MAX})
                      ? bst_pkg::VALUE_MAX : acc_wide[bst_pkg::VALUE_W-1:0];

    // String length clipped to the width of the remaining-byte counter.
    assign len_sat = (|acc_reg[bst_pkg::VALUE_W-1:LENGTH_BITS])
                     ? {LENGTH_BITS{1'b1}} : acc_reg[LENGTH_BITS-1:0];

    assign lvl_old_field = clamp_level(lvl_reg);

    // Next parse state and the token record for the current byte.
    always_comb
    begin
        logic [1:0] slot;
        logic       do_idle;
        logic       corrupt;
        slot      = 2'd0;
        do_idle   = 1'b0;
        corrupt   = 1'b0;
        mode_next = mode_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        lvl_next  = lvl_reg;
        rec       = '0;

        case (mode_reg)
            bst_pkg::MODE_LEN:
            begin
                if (is_digit) begin
                    acc_next = acc_step;
                end else if (in_byte == bst_pkg::CH_COLON) begin
                    if (acc_reg == '0) begin
                        mode_next = bst_pkg::MODE_IDLE;
                        rec.kind[slot]  = bst_pkg::TK_EMPTY;
                        rec.level[slot] = lvl_old_field;
                        slot = slot + 2'd1;
                    end else begin
                        rem_next  = len_sat;
                        mode_next = bst_pkg::MODE_PAY;
                    end
                    acc_next = '0;
                end else begin
                    rec.kind[slot]  = bst_pkg::TK_NOCOLON;
                    rec.level[slot] = lvl_old_field;
                    slot = slot + 2'd1;
                    mode_next = bst_pkg::MODE_IDLE;
                    acc_next  = '0;
                    do_idle   = 1'b1;
                end
            end
            bst_pkg::MODE_INT:
            begin
                if (is_digit) begin
                    acc_next = acc_step;
                end else if (in_byte == bst_pkg::CH_E) begin
                    rec.kind[slot]  = bst_pkg::TK_INT;
                    rec.level[slot] = lvl_old_field;
                    rec.value       = acc_reg;
                    slot = slot + 2'd1;
                    mode_next = bst_pkg::MODE_IDLE;
                    acc_next  = '0;
                end else begin
                    rec.kind[slot]  = bst_pkg::TK_NOE;
                    rec.level[slot] = lvl_old_field;
                    slot = slot + 2'd1;
                    mode_next = bst_pkg::MODE_IDLE;
                    acc_next  = '0;
                    do_idle   = 1'b1;
                end
            end
            bst_pkg::MODE_PAY:
            begin
                if (rem_reg != '0)
                    rem_next = rem_reg - 1'b1;
                if (rem_next == '0)
                    mode_next = bst_pkg::MODE_IDLE;
                rec.kind[slot]  = bst_pkg::TK_BYTE;
                rec.level[slot] = lvl_old_field;
                rec.payload     = in_byte;
                rec.str_end     = (rem_next == '0);
                slot = slot + 2'd1;
            end
            default:
            begin
                do_idle = 1'b1;
            end
        endcase

        // Byte handled outside any token: structure and token starts.
        if (do_idle) begin
            if (in_byte == bst_pkg::CH_D) begin
                if (lvl_reg < LVL_MAX)
                    lvl_next = lvl_reg + 1'b1;
                rec.kind[slot]  = bst_pkg::TK_OPEN;
                rec.level[slot] = clamp_level(lvl_next);
                slot = slot + 2'd1;
            end else if (in_byte == bst_pkg::CH_E) begin
                if (lvl_reg > LVL_MIN)
                    lvl_next = lvl_reg - 1'b1;
                rec.kind[slot]  = bst_pkg::TK_CLOSE;
                rec.level[slot] = clamp_level(lvl_next);
                slot = slot + 2'd1;
            end else if (in_byte == bst_pkg::CH_I) begin
                mode_next = bst_pkg::MODE_INT;
                acc_next  = '0;
            end else if (is_digit) begin
                mode_next = bst_pkg::MODE_LEN;
                acc_next  = {{(bst_pkg::VALUE_W-4){1'b0}}, digit};
            end
        end

        // End of stream: flush pending digits, report, and start over.
        // The end tokens carry the level reached before the state is cleared.
        if (in_eos) begin
            if (mode_next == bst_pkg::MODE_LEN) begin
                rec.kind[slot]  = bst_pkg::TK_NOCOLON;
                rec.level[slot] = clamp_level(lvl_next);
                slot = slot + 2'd1;
            end else if (mode_next == bst_pkg::MODE_INT) begin
                rec.kind[slot]  = bst_pkg::TK_NOE;
                rec.level[slot] = clamp_level(lvl_next);
                slot = slot + 2'd1;
            end
            corrupt = (lvl_next != '0)
                      || ((mode_next == bst_pkg::MODE_PAY) && (rem_next != '0));
            rec.kind[slot]  = corrupt ? bst_pkg::TK_CORRUPT : bst_pkg::TK_END_OK;
            rec.level[slot] = clamp_level(lvl_next);
            slot = slot + 2'd1;
            mode_next = bst_pkg::MODE_IDLE;
            acc_next  = '0;
            rem_next  = '0;
            lvl_next  = '0;
        end

        rec.count = slot;
    end

    // Records with no tokens are not queued.
    assign push = accept && (rec.count != 2'd0);

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= bst_pkg::MODE_IDLE;
            acc_reg  <= '0;
            rem_reg  <= '0;
            lvl_reg  <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            rem_reg  <= rem_next;
            lvl_reg  <= lvl_next;
        end
    end

endmodule

/* rtl/core/bst_queue.sv */
// Short record queue between the parser front end and the token emitter.
// Depends on bst_pkg for the record type.
module bst_queue #(
    parameter int DEPTH = bst_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bst_pkg::step_rec_t push_rec,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output bst_pkg::step_rec_t head_rec
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bst_pkg::step_rec_t mem [DEPTH];
    logic [PW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]      count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_rec  = mem[rd_ptr_reg];

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_rec;
    end

endmodule

/* rtl/core/bst_emit.sv */
// Token emitter: walks the tokens of the queued record into a registered output
// stage, one per cycle while it is empty or taken. Depends on bst_pkg.
module bst_emit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rec_valid,
    input  bst_pkg::step_rec_t                rec,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bst_pkg::KIND_W-1:0]        out_kind,
    output logic [bst_pkg::BYTE_W-1:0]        out_payload,
    output logic [bst_pkg::VALUE_W-1:0]       out_value,
    output logic                              out_str_end,
    output logic [bst_pkg::NEST_W-1:0]        out_level,
    output logic                              out_last
);

    logic [1:0]                        idx_reg, idx_next;
    logic                              valid_reg, valid_next;
    logic [bst_pkg::KIND_W-1:0]        kind_reg;
    logic [bst_pkg::BYTE_W-1:0]        payload_reg;
    logic [bst_pkg::VALUE_W-1:0]       value_reg;
    logic                              str_end_reg;
    logic [bst_pkg::NEST_W-1:0]        level_reg;
    logic                              last_reg;

    logic                              load;
    logic                              is_last;
    logic                              first;

    // Load the next token whenever the output stage is empty or being taken.
    assign load    = rec_valid && (!valid_reg || out_ready);
    assign is_last = (idx_reg == (rec.count - 2'd1));
    assign first   = (idx_reg == 2'd0);
    assign pop     = load && is_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            idx_next   = is_last ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload; value fields travel only with the first token.
    always_ff @(posedge clk)
    begin
        if (load) begin
            kind_reg    <= rec.kind[idx_reg];
            level_reg   <= rec.level[idx_reg];
            payload_reg <= first ? rec.payload : '0;
            value_reg   <= first ? rec.value : '0;
            str_end_reg <= first ? rec.str_end : 1'b0;
            last_reg    <= is_last;
        end
    end

    assign out_valid   = valid_reg;
    assign out_kind    = kind_reg;
    assign out_payload = payload_reg;
    assign out_value   = value_reg;
    assign out_str_end = str_end_reg;
    assign out_level   = level_reg;
    assign out_last    = last_reg;

endmodule

/* rtl/core/bencode_stream_tokenizer_core.sv */
// Top level of the bencode stream tokenizer: parser front end, record queue
// and token emitter. Depends on bst_pkg, bst_front, bst_queue and bst_emit.
//
// Usage:
//   The slave stream carries one byte of a bencoded stream per transfer,
//   with tlast set on the final byte of the stream. The master stream
//   carries tokens: string payload bytes, empty strings, integers,
//   dictionary opens and closes, error tokens and one end token per stream.
//   tlast on the master side marks the last token caused by one input byte;
//   bytes that cause no token (digits, 'i', list bytes) produce nothing.
//   The first token of a byte passes through the record queue and then the
//   output register. Bytes are taken one per cycle while the queue is not
//   full; a byte that causes two or three tokens sends them one after another,
//   and the single output register is what bounds the token rate to one per cycle.
//   A record queue of QUEUE_DEPTH entries sits between parser and output,
//   so when the receiver stalls, input keeps flowing until the queue fills
//   and s_axis_tready falls. Reset clears the parse state, the nesting
//   level, the queue and the output stage; no tokens are pending after it.
//   After the end token the parser is back in its reset state.
module bencode_stream_tokenizer_core #(
    parameter int LENGTH_BITS = bst_pkg::LENGTH_BITS_DEF,
    parameter int LEVEL_BITS  = bst_pkg::LEVEL_BITS_DEF,
    parameter int QUEUE_DEPTH = bst_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic        s_axis_tlast,   // end_of_stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] payload_byte, [70:8] integer_value, [71] string_end,
    // [79:72] nesting_level
    output logic [79:0] m_axis_tdata,
    output logic [3:0]  m_axis_tuser,   // [3:0] token_kind
    output logic        m_axis_tlast    // last
);

    logic                               queue_full;
    logic                               push;
    bst_pkg::step_rec_t                 push_rec;
    logic                               pop;
    logic                               not_empty;
    bst_pkg::step_rec_t                 head_rec;
    logic [bst_pkg::BYTE_W-1:0]         payload;
    logic [bst_pkg::VALUE_W-1:0]        value;
    logic                               str_end;
    logic [bst_pkg::NEST_W-1:0]         level;

    bst_front #(
        .LENGTH_BITS (LENGTH_BITS),
        .LEVEL_BITS  (LEVEL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_eos     (s_axis_tlast),
        .queue_full (queue_full),
        .push       (push),
        .rec        (push_rec)
    );

    bst_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .head_rec  (head_rec)
    );

    bst_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .rec_valid   (not_empty),
        .rec         (head_rec),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_kind    (m_axis_tuser),
        .out_payload (payload),
        .out_value   (value),
        .out_str_end (str_end),
        .out_level   (level),
        .out_last    (m_axis_tlast)
    );

    // Pack the token fields, lowest field first.
    assign m_axis_tdata = {level, str_end, value, payload};

endmodule

/* tb/bencode_token_checker.sv */
// Token checker for the bencode stream tokenizer: watches both stream ports,
// predicts the tokens of every accepted byte and compares them in order.
// Depends on bst_pkg for field widths, byte codes, parser modes and token kinds.
module bencode_token_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] byte_in
    input  logic        s_tlast,    // end_of_stream
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] payload_byte, [70:8] integer_value, [71] string_end,
    // [79:72] nesting_level
    input  logic [79:0] m_tdata,
    input  logic [3:0]  m_tuser,    // [3:0] token_kind
    input  logic        m_tlast,    // last
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // One token as it should appear on the output port.
    typedef struct packed {
        logic [bst_pkg::KIND_W-1:0]  kind;
        logic [bst_pkg::BYTE_W-1:0]  payload;
        logic [bst_pkg::VALUE_W-1:0] value;
        logic                        str_end;
        logic [bst_pkg::NEST_W-1:0]  level;
        logic                        last;
    } token_t;

    localparam logic [63:0] LEN_MAX   = (64'd1 << bst_pkg::LENGTH_BITS_DEF) - 64'd1;
    localparam logic [63:0] DIGIT_MAX = {1'b0, bst_pkg::VALUE_MAX};
    localparam int          LEVEL_MAX = (1 << (bst_pkg::LEVEL_BITS_DEF - 1)) - 1;
    localparam int          LEVEL_MIN = -LEVEL_MAX - 1;

    // Parser state as the tokenizer should hold it.
    bst_pkg::mode_t mode;
    logic [63:0]    digits;
    logic [63:0]    remaining;
    int             depth;

    token_t      step_tokens [bst_pkg::SLOTS];
    int          step_count;
    token_t      expected_tokens [$];

    function automatic void reset_state();
        mode      = bst_pkg::MODE_IDLE;
        digits    = '0;
        remaining = '0;
        depth     = 0;
    endfunction

    // The nesting level is reported clamped to the signed 8-bit range.
    function automatic logic [bst_pkg::NEST_W-1:0] reported_level();
        int v;
        v = depth;
        if (v > 127)
            v = 127;
        if (v < -128)
            v = -128;
        return v[bst_pkg::NEST_W-1:0];
    endfunction

    function automatic void add_token(bst_pkg::tok_kind_t kind, logic [7:0] pb,
                                      logic [bst_pkg::VALUE_W-1:0] val, logic send);
        step_tokens[step_count] = '{kind: kind, payload: pb, value: val,
                                    str_end: send, level: reported_level(),
                                    last: 1'b0};
        step_count++;
    endfunction

    function automatic bit is_digit(logic [7:0] b);
        return b >= bst_pkg::CH_0 && b <= bst_pkg::CH_9;
    endfunction

    // Decimal accumulation that sticks at the largest 63-bit value.
    function automatic void accumulate_digit(logic [7:0] b);
        logic [63:0] d;
        d = 64'(b - bst_pkg::CH_0);
        if (digits > (DIGIT_MAX - d) / 64'd10)
            digits = DIGIT_MAX;
        else
            digits = digits * 64'd10 + d;
    endfunction

    function automatic void start_digits(bst_pkg::mode_t next_mode);
        mode   = next_mode;
        digits = '0;
    endfunction

    // Handling of a byte outside any string or number.
    function automatic void idle_byte(logic [7:0] b);
        if (b == bst_pkg::CH_D) begin
            if (depth < LEVEL_MAX)
                depth++;
            add_token(bst_pkg::TK_OPEN, 8'd0, '0, 1'b0);
        end
        else if (b == bst_pkg::CH_E) begin
            if (depth > LEVEL_MIN)
                depth--;
            add_token(bst_pkg::TK_CLOSE, 8'd0, '0, 1'b0);
        end
        else if (b == bst_pkg::CH_I) begin
            start_digits(bst_pkg::MODE_INT);
        end
        else if (is_digit(b)) begin
            start_digits(bst_pkg::MODE_LEN);
            accumulate_digit(b);
        end
    endfunction

    // Works out every token one accepted byte causes and queues them.
    function automatic void tokenize_byte(logic [7:0] b, logic eos);
        bit corrupt;
        step_count = 0;
        case (mode)
            bst_pkg::MODE_LEN: begin
                if (is_digit(b)) begin
                    accumulate_digit(b);
                end
                else if (b == bst_pkg::CH_COLON) begin
                    if (digits == 0) begin
                        mode = bst_pkg::MODE_IDLE;
                        add_token(bst_pkg::TK_EMPTY, 8'd0, '0, 1'b0);
                    end
                    else begin
                        remaining = (digits > LEN_MAX) ? LEN_MAX : digits;
                        mode      = bst_pkg::MODE_PAY;
                    end
                    digits = '0;
                end
                else begin
                    add_token(bst_pkg::TK_NOCOLON, 8'd0, '0, 1'b0);
                    start_digits(bst_pkg::MODE_IDLE);
                    idle_byte(b);
                end
            end
            bst_pkg::MODE_INT: begin
                if (is_digit(b)) begin
                    accumulate_digit(b);
                end
                else if (b == bst_pkg::CH_E) begin
                    add_token(bst_pkg::TK_INT, 8'd0, digits[bst_pkg::VALUE_W-1:0], 1'b0);
                    start_digits(bst_pkg::MODE_IDLE);
                end
                else begin
                    add_token(bst_pkg::TK_NOE, 8'd0, '0, 1'b0);
                    start_digits(bst_pkg::MODE_IDLE);
                    idle_byte(b);
                end
            end
            bst_pkg::MODE_PAY: begin
                if (remaining > 0)
                    remaining--;
                if (remaining == 0)
                    mode = bst_pkg::MODE_IDLE;
                add_token(bst_pkg::TK_BYTE, b, '0, remaining == 0);
            end
            default: begin
                mode = bst_pkg::MODE_IDLE;
                idle_byte(b);
            end
        endcase

        // The final byte of a stream flushes pending digits and reports.
        if (eos) begin
            if (mode == bst_pkg::MODE_LEN)
                add_token(bst_pkg::TK_NOCOLON, 8'd0, '0, 1'b0);
            else if (mode == bst_pkg::MODE_INT)
                add_token(bst_pkg::TK_NOE, 8'd0, '0, 1'b0);
            corrupt = depth != 0 || (mode == bst_pkg::MODE_PAY && remaining > 0);
            add_token(corrupt ? bst_pkg::TK_CORRUPT : bst_pkg::TK_END_OK, 8'd0, '0, 1'b0);
            reset_state();
        end

        if (step_count > 0)
            step_tokens[step_count-1].last = 1'b1;
        for (int i = 0; i < step_count; i++)
            expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
    endfunction

    function automatic void check_field(string name, logic [63:0] want,
                                        logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Input transfers feed the prediction before output transfers are compared.
    always @(posedge clk or negedge rst_n) begin
        token_t want;
        if (!rst_n) begin
            reset_state();
            expected_tokens.delete();
            mismatches = 0;
        end
        else begin
            if (s_tvalid && s_tready)
                tokenize_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (expected_tokens.size() == 0) begin
                    $error("token_kind mismatch: expected none, actual %0d", m_tuser);
                    mismatches++;
                end
                else begin
                    want = expected_tokens.pop_front();
                    check_field("token_kind", want.kind, m_tuser);
                    check_field("payload_byte", want.payload, m_tdata[7:0]);
                    check_field("integer_value", want.value, m_tdata[70:8]);
                    check_field("string_end", want.str_end, m_tdata[71]);
                    check_field("nesting_level", want.level, m_tdata[79:72]);
                    check_field("last", want.last, m_tlast);
                end
            end
        end
        outstanding <= expected_tokens.size();
    end

endmodule

/* tb/tb_bencode_stream_tokenizer_core.sv */
// Testbench top for the bencode stream tokenizer: drives bencoded streams with
// bursty input and a stalling receiver, and gives the verdict.
// Depends on bst_pkg, bencode_stream_tokenizer_core and bencode_token_checker.
module tb_bencode_stream_tokenizer_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CH_L        = 8'h6C;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam int         TOTAL_ITEMS  = 320;
    localparam int         HOLD_CYCLES  = 120;
    localparam int         DRAIN_CYCLES = 40;

    typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_pattern_t;
    typedef enum int {DAMAGE_REPLACE, DAMAGE_CUT, DAMAGE_INSERT, DAMAGE_LONG_LENGTH}
        damage_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        hold_req;
    int          mismatches;
    int          outstanding;

    // Stream under construction and the sender's burst bookkeeping.
    logic [7:0]  doc [$];
    int          sent_count;
    int          burst_left;

    bencode_stream_tokenizer_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    bencode_token_checker token_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .s_tdata     (s_axis_tdata),
        .s_tlast     (s_axis_tlast),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .m_tuser     (m_axis_tuser),
        .m_tlast     (m_axis_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Offers one byte and waits for its transfer; a finished burst ends in a gap.
    task automatic send_byte(input logic [7:0] b, input bit eos);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent_count++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
    endtask

    task automatic send_text(input string s, input bit eos);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eos && i == s.len() - 1);
    endtask

    task automatic send_document();
        for (int i = 0; i < doc.size(); i++)
            send_byte(doc[i], i == doc.size() - 1);
    endtask

    // Appends one byte to the stream under construction.
    function automatic void append_byte(logic [7:0] b);
        doc.insert(doc.size(), b);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            append_byte(s[i]);
    endfunction

    function automatic void add_digits(int count);
        repeat (count) append_byte(bst_pkg::CH_0 + 8'($urandom_range(0, 9)));
    endfunction

    // A string item: length, colon and random payload, now and then zero-padded.
    function automatic void add_string_item();
        int len;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            len = 0;
        else if (pick == 9)
            len = $urandom_range(9, 40);
        else
            len = $urandom_range(1, 8);
        if ($urandom_range(0, 9) == 0)
            append_byte(bst_pkg::CH_0);
        add_text($sformatf("%0d", len));
        append_byte(bst_pkg::CH_COLON);
        repeat (len) append_byte(8'($urandom));
    endfunction

    // An integer item; long ones start with a nine so that most overflow.
    function automatic void add_int_item();
        append_byte(bst_pkg::CH_I);
        if ($urandom_range(0, 9) == 0)
            append_byte(CH_MINUS);
        if ($urandom_range(0, 6) == 0) begin
            append_byte(bst_pkg::CH_9);
            add_digits($urandom_range(17, 21));
        end
        else begin
            add_digits($urandom_range(1, 6));
        end
        append_byte(bst_pkg::CH_E);
    endfunction

    // A balanced stream of strings, integers, dictionaries and lists.
    function automatic void build_document();
        int items;
        int pick;
        int open_count;
        doc.delete();
        open_count = 0;
        items = $urandom_range(1, 8);
        for (int i = 0; i < items; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                add_string_item();
            end
            else if (pick < 7) begin
                add_int_item();
            end
            else if (pick < 9 && open_count < 4) begin
                if (pick == 7)
                    append_byte(bst_pkg::CH_D);
                else
                    append_byte(CH_L);
                open_count++;
            end
            else if (open_count > 0) begin
                append_byte(bst_pkg::CH_E);
                open_count--;
            end
            else begin
                add_string_item();
            end
        end
        repeat (open_count) append_byte(bst_pkg::CH_E);
    endfunction

    // Breaks a well-formed stream in one of several ways.
    function automatic void damage_document();
        int pos;
        pos = $urandom_range(0, doc.size() - 1);
        case (damage_t'($urandom_range(0, 3)))
            DAMAGE_REPLACE:
                doc[pos] = 8'($urandom);
            DAMAGE_CUT:
                while (doc.size() > pos + 1)
                    doc.delete(doc.size() - 1);
            DAMAGE_INSERT:
                doc.insert(pos, 8'($urandom));
            default: begin
                // A length too long to be met before the stream ends.
                append_byte(bst_pkg::CH_9);
                add_digits($urandom_range(9, 20));
                append_byte(bst_pkg::CH_COLON);
                repeat ($urandom_range(0, 2)) append_byte(8'($urandom));
            end
        endcase
    endfunction

    // Short runs of bytes, half of them drawn from the significant ones.
    function automatic void build_noise();
        logic [7:0] marks [8];
        marks = '{bst_pkg::CH_D, bst_pkg::CH_E, bst_pkg::CH_I, bst_pkg::CH_COLON,
                  bst_pkg::CH_0, bst_pkg::CH_9, CH_L, CH_MINUS};
        doc.delete();
        repeat ($urandom_range(1, 10)) begin
            if ($urandom_range(0, 1) == 0)
                append_byte(marks[$urandom_range(0, 7)]);
            else
                append_byte(8'($urandom));
        end
    endfunction

    // Receiver: changes its stall pattern after each random span and holds off
    // for one long stretch when asked.
    initial
    begin
        rx_pattern_t pattern;
        int          span;
        bit          hold_done;
        pattern   = RX_ALWAYS;
        span      = 0;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_done = 1'b1;
            end
            else begin
                if (span == 0) begin
                    pattern = rx_pattern_t'($urandom_range(0, 3));
                    span    = $urandom_range(10, 60);
                end
                span--;
                case (pattern)
                    RX_ALWAYS: m_axis_tready <= 1'b1;
                    RX_HALF:   m_axis_tready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int count;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        s_axis_tlast  <= 1'b0;
        hold_req      <= 1'b0;
        burst_left    = 1;
        sent_count    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Open, a string with extreme payload bytes, integer zero, close.
        send_text("d3:", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_text("i0ee", 1'b1);
        // Empty string, missing colon, missing e, end with pending length digits.
        send_text("0:5di7dee4", 1'b1);
        // Close without open ends corrupt.
        send_text("e", 1'b1);
        // String still short of payload at the end.
        send_text("3:a", 1'b1);
        // End with pending integer digits.
        send_text("i5", 1'b1);

        // Long receiver hold-off while the sender keeps offering.
        hold_req   <= 1'b1;
        burst_left = 200;

        // Nesting past the top of the level range, then closes from there.
        count = $urandom_range(128, 132);
        doc.delete();
        repeat (count) append_byte(bst_pkg::CH_D);
        repeat (4) append_byte(bst_pkg::CH_E);
        send_document();

        while (sent_count < TOTAL_ITEMS) begin
            if ($urandom_range(0, 11) == 0) begin
                build_noise();
            end
            else begin
                build_document();
                if ($urandom_range(0, 4) == 0)
                    damage_document();
            end
            send_document();
        end
        s_axis_tvalid <= 1'b0;

        // Wait so that the count covers the final transfer.
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
